[rtl/core/slwt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot last-writer table package
// Shared types, codes and sizing constants for the last-writer table.
// ----------------------------------------------------------------------------
package slwt_pkg;

	localparam int ADDR_BITS       = 48;
	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int PROBE_LIMIT_DEF = 32;
	localparam int BULK_MAX_SLOTS  = 1 << 16;
	localparam int RANGE_BITS      = 50;

	localparam logic [15:0] DUMP_RESET = 16'd64;

	// Operation codes.
	localparam logic [1:0] OP_TYPED   = 2'd0;
	localparam logic [1:0] OP_BULK    = 2'd1;
	localparam logic [1:0] OP_CONSUME = 2'd2;

	// Value kinds.
	localparam logic [2:0] KIND_BASE     = 3'd0;
	localparam logic [2:0] KIND_INTERIOR = 3'd1;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd2;
	localparam logic [2:0] KIND_NULL     = 3'd4;

	// Writer codes.
	localparam logic [1:0] WR_NONE  = 2'd0;
	localparam logic [1:0] WR_TYPED = 2'd1;
	localparam logic [1:0] WR_BULK  = 2'd2;

	// Verdict codes.
	localparam logic [3:0] V_TYPED_STORED = 4'd0;
	localparam logic [3:0] V_IGNORED      = 4'd1;
	localparam logic [3:0] V_BULK_DONE    = 4'd2;
	localparam logic [3:0] V_NOT_INTERIOR = 4'd3;
	localparam logic [3:0] V_NO_RECORD    = 4'd4;
	localparam logic [3:0] V_WR_INTERIOR  = 4'd5;
	localparam logic [3:0] V_RECLASSIFIED = 4'd6;
	localparam logic [3:0] V_MUTATED      = 4'd7;
	localparam logic [3:0] V_TYPED_OTHER  = 4'd8;
	localparam logic [3:0] V_BULK_LAST    = 4'd9;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] slot_addr;
		logic [47:0] item_value;
		logic [2:0]  value_kind;
		logic [31:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic        report;
		logic [16:0] slots_recorded;
		logic [63:0] record_seq;
		logic [47:0] record_value;
		logic [2:0]  record_kind;
		logic [1:0]  record_writer;
	} rsp_t;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [ADDR_BITS-1:0] key;
		logic [63:0]          seq;
		logic [47:0]          value;
		logic [1:0]           writer;
		logic [2:0]           kind;
	} entry_t;

endpackage

[rtl/core/slwt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slwt_mem #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 165
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/slot_last_writer_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot last-writer table core
// Linear-probing table keyed by 8-byte slot address; records typed and bulk
// writes and classifies remembered-set consumes against the stored history.
// ----------------------------------------------------------------------------
// Ignored items answer in the cycle after start; a typed write or consume
// probes up to PROBE_LIMIT positions from its home index, then answers from
// the act state. A bulk range probes and records each aligned slot in turn,
// then answers when it closes. Probes are limited by the single read port of
// the table memory, one probe per cycle. A clearing pass after reset holds busy high.
// Results appear on rsp for one cycle with done; the receiver cannot stall.
module slot_last_writer_table_core
	import slwt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int PW    = $clog2(PROBE_LIMIT + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_BULK  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_ACT   = 3'd4;

	logic [2:0]            state_q;
	logic [IDX_W:0]        clr_q;
	logic [1:0]            op_q;
	logic [ADDR_BITS-1:0]  key_q;
	logic [47:0]           value_q;
	logic [2:0]            kind_q;
	logic [RANGE_BITS-1:0] cur_q;
	logic [RANGE_BITS-1:0] end_q;
	logic [16:0]           n_q;
	logic [63:0]           next_seq_q;
	logic [15:0]           dumps_q;
	logic [PW-1:0]         p_q;
	logic                  found_q;
	logic [IDX_W-1:0]      j_q;
	entry_t                ent_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  rd_v_s1;
	logic [PW-1:0]         rd_p_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	entry_t                mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	entry_t                mem_rdata;

	logic [IDX_W-1:0]      home;
	logic [IDX_W:0]        psum;
	logic                  hit_now;
	logic                  last_now;
	logic                  accept;
	logic                  bulk_more;
	entry_t                new_ent;
	logic [2:0]            typed_kind;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// Home index and wrapped probe address.
	assign home = key_q[3 +: IDX_W];
	always_comb begin
		psum = {1'b0, home} + (IDX_W + 1)'(p_q);
		if (psum >= (IDX_W + 1)'(TABLE_DEPTH)) begin
			psum = psum - (IDX_W + 1)'(TABLE_DEPTH);
		end
	end
	assign mem_raddr = psum[IDX_W-1:0];
	assign mem_re    = (state_q == ST_PROBE) && (p_q < PW'(PROBE_LIMIT));

	// Probe result evaluation; empty entries match only for inserts.
	assign hit_now  = rd_v_s1 && ((mem_rdata.key == key_q) ||
		((op_q != OP_CONSUME) && (mem_rdata.key == '0)));
	assign last_now = rd_v_s1 && (rd_p_s1 == PW'(PROBE_LIMIT - 1));

	assign bulk_more = ((cur_q + RANGE_BITS'(8)) <= end_q);

	// Record written by an insert.
	always_comb begin
		new_ent.key = key_q;
		new_ent.seq = next_seq_q;
		if (op_q == OP_TYPED) begin
			new_ent.value  = value_q;
			new_ent.kind   = kind_q;
			new_ent.writer = WR_TYPED;
		end else begin
			new_ent.value  = '0;
			new_ent.kind   = KIND_UNKNOWN;
			new_ent.writer = WR_BULK;
		end
	end

	// Memory write source: clearing pass or an insert.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = new_ent;
		if (state_q == ST_CLEAR) begin
			mem_we           = 1'b1;
			mem_waddr        = clr_q[IDX_W-1:0];
			mem_wdata        = '0;
			mem_wdata.kind   = KIND_UNKNOWN;
		end else if ((state_q == ST_ACT) && (op_q != OP_CONSUME)) begin
			mem_we = 1'b1;
		end
	end

	assign typed_kind = (req.value_kind > KIND_NULL) ? KIND_UNKNOWN : req.value_kind;

	slwt_mem #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH($bits(entry_t))
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Read pipeline tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_p_s1   <= p_q;
		rd_idx_s1 <= mem_raddr;
	end

	// Control sequencer, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			next_seq_q <= 64'd1;
			dumps_q    <= DUMP_RESET;
			done_q     <= 1'b0;
			p_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				dumps_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IDX_W + 1)'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rsp_q         <= '0;
						rsp_q.verdict <= V_IGNORED;
						op_q          <= req.opcode;
						key_q         <= req.slot_addr;
						value_q       <= req.item_value;
						kind_q        <= typed_kind;
						p_q           <= '0;
						n_q           <= '0;
						cur_q         <= (RANGE_BITS'(req.slot_addr) + RANGE_BITS'(7)) &
							~RANGE_BITS'(7);
						end_q         <= RANGE_BITS'(req.slot_addr) +
							RANGE_BITS'(req.byte_count);
						case (req.opcode)
							OP_TYPED: begin
								if ((req.slot_addr == '0) || (req.slot_addr[2:0] != 3'd0)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_PROBE;
								end
							end
							OP_BULK: begin
								if (req.byte_count == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_BULK;
								end
							end
							OP_CONSUME: begin
								if (req.value_kind != KIND_INTERIOR) begin
									rsp_q.verdict <= V_NOT_INTERIOR;
									done_q        <= 1'b1;
								end else begin
									state_q <= ST_PROBE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_BULK: begin
					// Next aligned slot of the range, or close the range.
					if (bulk_more) begin
						key_q   <= cur_q[ADDR_BITS-1:0];
						p_q     <= '0;
						state_q <= ST_PROBE;
					end else begin
						rsp_q.verdict        <= V_BULK_DONE;
						rsp_q.slots_recorded <= n_q;
						done_q               <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				ST_PROBE: begin
					if (mem_re) begin
						p_q <= p_q + 1'b1;
					end
					if (hit_now) begin
						found_q <= 1'b1;
						j_q     <= rd_idx_s1;
						ent_q   <= mem_rdata;
						state_q <= ST_ACT;
					end else if (last_now) begin
						found_q <= 1'b0;
						j_q     <= home;
						ent_q   <= mem_rdata;
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					case (op_q)
						OP_TYPED: begin
							next_seq_q          <= next_seq_q + 1'b1;
							rsp_q.verdict       <= V_TYPED_STORED;
							rsp_q.record_seq    <= next_seq_q;
							rsp_q.record_value  <= value_q;
							rsp_q.record_kind   <= kind_q;
							rsp_q.record_writer <= WR_TYPED;
							if ((kind_q == KIND_INTERIOR) && (dumps_q != '0)) begin
								rsp_q.report <= 1'b1;
								dumps_q      <= dumps_q - 1'b1;
							end
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						OP_BULK: begin
							next_seq_q <= next_seq_q + 1'b1;
							n_q        <= n_q + 1'b1;
							cur_q      <= cur_q + RANGE_BITS'(8);
							if ((n_q + 1'b1) > 17'(BULK_MAX_SLOTS)) begin
								rsp_q.verdict        <= V_BULK_DONE;
								rsp_q.slots_recorded <= n_q + 1'b1;
								done_q               <= 1'b1;
								state_q              <= ST_IDLE;
							end else begin
								state_q <= ST_BULK;
							end
						end
						default: begin
							// Remembered-set consume: classify the stored history.
							rsp_q.verdict <= V_NO_RECORD;
							if (found_q && (ent_q.writer != WR_NONE)) begin
								if (ent_q.writer == WR_TYPED) begin
									if (ent_q.value != value_q) begin
										rsp_q.verdict <= V_MUTATED;
									end else if (ent_q.kind == KIND_INTERIOR) begin
										rsp_q.verdict <= V_WR_INTERIOR;
									end else if (ent_q.kind == KIND_BASE) begin
										rsp_q.verdict <= V_RECLASSIFIED;
									end else begin
										rsp_q.verdict <= V_TYPED_OTHER;
									end
									rsp_q.record_seq    <= ent_q.seq;
									rsp_q.record_value  <= ent_q.value;
									rsp_q.record_kind   <= ent_q.kind;
									rsp_q.record_writer <= ent_q.writer;
								end else if (ent_q.writer == WR_BULK) begin
									rsp_q.verdict       <= V_BULK_LAST;
									rsp_q.record_seq    <= ent_q.seq;
									rsp_q.record_value  <= ent_q.value;
									rsp_q.record_kind   <= ent_q.kind;
									rsp_q.record_writer <= ent_q.writer;
								end
							end
							if (dumps_q != '0) begin
								rsp_q.report <= 1'b1;
								dumps_q      <= dumps_q - 1'b1;
							end
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot last-writer table testbench
// Drives typed writes, bulk ranges and remembered-set consumes into the core,
// predicts every response with a table model of its own and compares each
// response field by field. The report budget is reloaded between phases.
// ----------------------------------------------------------------------------
module testbench;
	import slwt_pkg::*;

	localparam int DEPTH       = 4096;
	localparam int PROBES      = 32;
	localparam int IDLE_LIMIT  = 8_000_000;
	localparam int DRAIN_WAIT  = 40;

	// Table model holding the expected history of every slot.
	class slot_history_model;
		bit [47:0] keys [DEPTH];
		bit [63:0] seqs [DEPTH];
		bit [47:0] vals [DEPTH];
		bit [1:0]  writers [DEPTH];
		bit [2:0]  kinds [DEPTH];
		bit [63:0] next_seq;
		bit [15:0] dumps_left;
		rsp_t      pending_rsp [$];
		int        errors;
		int        verdict_seen [16];

		function void clear();
			for (int i = 0; i < DEPTH; i++) begin
				keys[i] = '0;
				seqs[i] = '0;
				vals[i] = '0;
				writers[i] = WR_NONE;
				kinds[i] = KIND_UNKNOWN;
			end
			next_seq = 64'd1;
			dumps_left = DUMP_RESET;
			errors = 0;
		endfunction

		function void set_budget(bit [15:0] budget);
			dumps_left = budget;
		endfunction

		function bit take_report();
			if (dumps_left != 0) begin
				dumps_left--;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function int home_of(bit [47:0] key);
			return int'(key[14:3]);
		endfunction

		function int claim_entry(bit [47:0] key);
			int h;
			int j;
			h = home_of(key);
			for (int p = 0; p < PROBES; p++) begin
				j = (h + p) % DEPTH;
				if (keys[j] == key)
					return j;
				if (keys[j] == '0) begin
					keys[j] = key;
					return j;
				end
			end
			keys[h] = key;
			return h;
		endfunction

		function int locate_entry(bit [47:0] key);
			int j;
			for (int p = 0; p < PROBES; p++) begin
				j = (home_of(key) + p) % DEPTH;
				if (keys[j] == key)
					return j;
			end
			return -1;
		endfunction

		function void store_record(int j, bit [47:0] value, bit [2:0] kind, bit [1:0] writer);
			seqs[j] = next_seq;
			next_seq++;
			vals[j] = value;
			kinds[j] = kind;
			writers[j] = writer;
		endfunction

		function void show_record(int j, ref rsp_t r);
			r.record_seq = seqs[j];
			r.record_value = vals[j];
			r.record_kind = kinds[j];
			r.record_writer = writers[j];
		endfunction

		// Works out the response of one accepted request.
		function void note_request(req_t q);
			rsp_t      r;
			bit [2:0]  kind;
			bit [63:0] range_end;
			bit [63:0] cur;
			int        j;
			int        n;
			r = '0;
			r.verdict = V_IGNORED;
			kind = q.value_kind;
			if (q.opcode == OP_TYPED) begin
				if (q.slot_addr != '0 && q.slot_addr[2:0] == 3'd0) begin
					if (kind > KIND_NULL)
						kind = KIND_UNKNOWN;
					j = claim_entry(q.slot_addr);
					store_record(j, q.item_value, kind, WR_TYPED);
					r.verdict = V_TYPED_STORED;
					r.report = (kind == KIND_INTERIOR) && take_report();
					show_record(j, r);
				end
			end else if (q.opcode == OP_BULK) begin
				if (q.byte_count != '0) begin
					n = 0;
					range_end = 64'(q.slot_addr) + 64'(q.byte_count);
					cur = (64'(q.slot_addr) + 64'd7) & ~64'd7;
					while (cur + 64'd8 <= range_end) begin
						j = claim_entry(cur[47:0]);
						store_record(j, '0, KIND_UNKNOWN, WR_BULK);
						n++;
						cur += 64'd8;
						if (n > BULK_MAX_SLOTS)
							break;
					end
					r.verdict = V_BULK_DONE;
					r.slots_recorded = 17'(n);
				end
			end else if (q.opcode == OP_CONSUME) begin
				if (kind != KIND_INTERIOR) begin
					r.verdict = V_NOT_INTERIOR;
				end else begin
					r.verdict = V_NO_RECORD;
					j = locate_entry(q.slot_addr);
					if (j >= 0) begin
						if (writers[j] == WR_TYPED) begin
							if (vals[j] != q.item_value)
								r.verdict = V_MUTATED;
							else if (kinds[j] == KIND_INTERIOR)
								r.verdict = V_WR_INTERIOR;
							else if (kinds[j] == KIND_BASE)
								r.verdict = V_RECLASSIFIED;
							else
								r.verdict = V_TYPED_OTHER;
						end else if (writers[j] == WR_BULK) begin
							r.verdict = V_BULK_LAST;
						end
						if (r.verdict != V_NO_RECORD)
							show_record(j, r);
					end
					r.report = take_report();
				end
			end
			pending_rsp.push_back(r);
		endfunction

		// Compares one observed response with the oldest expected one.
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			verdict_seen[want.verdict]++;
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
				errors++;
			end
			if (got.report !== want.report) begin
				$error("report: expected %0d, actual %0d", want.report, got.report);
				errors++;
			end
			if (got.slots_recorded !== want.slots_recorded) begin
				$error("slots_recorded: expected %0d, actual %0d",
					want.slots_recorded, got.slots_recorded);
				errors++;
			end
			if (got.record_seq !== want.record_seq) begin
				$error("record_seq: expected %0d, actual %0d", want.record_seq, got.record_seq);
				errors++;
			end
			if (got.record_value !== want.record_value) begin
				$error("record_value: expected %h, actual %h",
					want.record_value, got.record_value);
				errors++;
			end
			if (got.record_kind !== want.record_kind) begin
				$error("record_kind: expected %0d, actual %0d", want.record_kind, got.record_kind);
				errors++;
			end
			if (got.record_writer !== want.record_writer) begin
				$error("record_writer: expected %0d, actual %0d",
					want.record_writer, got.record_writer);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	slot_history_model history;
	int                idle_cycles;
	int                sent;
	bit [47:0]         value_pool [4];

	slot_last_writer_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random pause, mostly short with a few long stretches.
	function int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Presents one request and holds it until the core takes it.
	task automatic send_request(req_t q);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= q;
		do
			@(posedge clk);
		while (!(start && !busy));
		history.note_request(q);
		sent++;
	endtask

	// Reloads the report budget once the core has gone quiet.
	task automatic write_budget(logic [15:0] budget);
		start <= 1'b0;
		while (history.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= budget;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		history.set_budget(budget);
	endtask

	function req_t make_req(logic [1:0] op, logic [47:0] slot, logic [47:0] value,
		logic [2:0] kind, logic [31:0] count);
		req_t q;
		q.opcode = op;
		q.slot_addr = slot;
		q.item_value = value;
		q.value_kind = kind;
		q.byte_count = count;
		return q;
	endfunction

	// Slot address drawn mostly from a pool of colliding keys.
	function logic [47:0] pick_slot();
		logic [47:0] bases [3];
		int          homes [4];
		logic [47:0] s;
		int          roll;
		bases[0] = 48'h0;
		bases[1] = 48'h07A5_0000_0000;
		bases[2] = 48'hFFFF_0000_0000;
		homes[0] = 1;
		homes[1] = 2;
		homes[2] = 100;
		homes[3] = 4095;
		s = bases[$urandom_range(2)] + 48'(homes[$urandom_range(3)] * 8)
			+ (48'($urandom_range(39)) << 15);
		roll = $urandom_range(99);
		if (roll < 60)
			return s;
		if (roll < 75)
			return 48'({$urandom(), $urandom()}) & ~48'd7;
		if (roll < 85)
			return 48'({$urandom(), $urandom()});
		if (roll < 90)
			return '0;
		return s | 48'($urandom_range(7, 1));
	endfunction

	function req_t random_req();
		req_t q;
		int   roll;
		q.slot_addr = pick_slot();
		q.item_value = ($urandom_range(99) < 70) ? value_pool[$urandom_range(3)]
			: 48'({$urandom(), $urandom()});
		q.value_kind = 3'($urandom_range(7));
		q.byte_count = '0;
		roll = $urandom_range(99);
		if (roll < 45) begin
			q.opcode = OP_TYPED;
			if ($urandom_range(2) == 0)
				q.value_kind = KIND_INTERIOR;
		end else if (roll < 85) begin
			q.opcode = OP_CONSUME;
			if ($urandom_range(3) != 0)
				q.value_kind = KIND_INTERIOR;
		end else if (roll < 97) begin
			q.opcode = OP_BULK;
			roll = $urandom_range(99);
			if (roll < 80)
				q.byte_count = $urandom_range(120, 1);
			else if (roll < 95)
				q.byte_count = '0;
			else
				q.byte_count = $urandom_range(3000, 121);
		end else begin
			q.opcode = 2'd3;
		end
		return q;
	endfunction

	task automatic random_phase(int count);
		repeat (count)
			send_request(random_req());
	endtask

	// Results are never held off, so every strobe is checked at once.
	always @(posedge clk) begin
		if (arst_n && done)
			history.check_response(rsp);
	end

	// Watchdog on cycles without any accepted transfer.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d idle cycles", IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		history = new();
		history.clear();
		sent = 0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		value_pool[2] = 48'h5555_AAAA_5555;
		value_pool[3] = 48'h0000_1234_5678;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset budget.
		send_request(make_req(OP_TYPED, 48'h0, 48'h1, KIND_BASE, '0));
		send_request(make_req(OP_TYPED, 48'h1001, 48'h1, KIND_BASE, '0));
		send_request(make_req(OP_TYPED, 48'h1000, '1, KIND_INTERIOR, '1));
		send_request(make_req(OP_TYPED, 48'h2000, 48'h22, 3'd7, '0));
		send_request(make_req(OP_CONSUME, 48'h1000, '1, KIND_INTERIOR, '0));
		send_request(make_req(OP_CONSUME, 48'h1000, 48'h5, KIND_INTERIOR, '0));
		send_request(make_req(OP_CONSUME, 48'h1000, '1, KIND_BASE, '0));
		send_request(make_req(OP_CONSUME, 48'h8000, '1, KIND_INTERIOR, '0));
		send_request(make_req(OP_TYPED, 48'h3000, 48'h7, KIND_BASE, '0));
		send_request(make_req(OP_CONSUME, 48'h3000, 48'h7, KIND_INTERIOR, '0));
		send_request(make_req(OP_CONSUME, 48'h2000, 48'h22, KIND_INTERIOR, '0));
		send_request(make_req(OP_BULK, 48'h4004, '0, KIND_BASE, '0));
		send_request(make_req(OP_BULK, 48'h4004, '0, KIND_BASE, 32'd30));
		send_request(make_req(OP_CONSUME, 48'h4010, '0, KIND_INTERIOR, '0));
		send_request(make_req(OP_CONSUME, 48'h0, '0, KIND_INTERIOR, '0));
		send_request(make_req(2'd3, '1, '1, 3'd7, '1));
		send_request(make_req(OP_BULK, 48'hFFFF_FFFF_FFF8, '0, KIND_NULL, 32'd24));
		send_request(make_req(OP_TYPED, 48'hFFFF_FFFF_FFF8, '0, KIND_NULL, '0));
		send_request(make_req(OP_CONSUME, 48'hFFFF_FFFF_FFF8, '0, KIND_INTERIOR, '0));
		send_request(make_req(OP_CONSUME, 48'h2000, 48'h22, 3'd6, '0));

		// Random phases under several budgets, extremes included.
		write_budget(16'd0);
		random_phase(400);
		write_budget(16'hFFFF);
		random_phase(400);
		write_budget(16'd1);
		random_phase(400);
		write_budget(16'($urandom_range(200, 2)));
		random_phase(350);

		// One full-length bulk range reaches the slot cap.
		send_request(make_req(OP_BULK, 48'({$urandom(), $urandom()}), '0, KIND_BASE, '1));
		start <= 1'b0;

		while (history.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (history.pending_rsp.size() != 0) begin
			$error("%0d responses never arrived", history.pending_rsp.size());
			history.errors++;
		end

		$display("Ran %0d requests over five report budgets, including a capped bulk range.",
			sent);
		$display("Verdicts seen: stored %0d, mutated %0d, bulk-last %0d, no-record %0d.",
			history.verdict_seen[V_TYPED_STORED], history.verdict_seen[V_MUTATED],
			history.verdict_seen[V_BULK_LAST], history.verdict_seen[V_NO_RECORD]);
		if (history.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/slwt_pkg.sv
rtl/core/slwt_mem.sv
rtl/core/slot_last_writer_table_core.sv
tb/testbench.sv
